@@ rtl/pce_pkg.sv @@
// Shared types and constants for the priority cache eviction block.
package pce_pkg;

    localparam int unsigned ENTRIES_DEF = 32;
    localparam int unsigned SLOT_W      = 6;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned SIZE_W      = 24;
    localparam int unsigned PRIO_W      = 16;
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    localparam logic [2:0] KIND_HIT   = 3'd0;
    localparam logic [2:0] KIND_INS   = 3'd1;
    localparam logic [2:0] KIND_EVICT = 3'd2;
    localparam logic [2:0] KIND_NOROOM = 3'd3;
    localparam logic [2:0] KIND_FLUSH = 3'd4;

    localparam logic REG_BUDGET = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_EVICT,
        OP_HIT,
        OP_INSERT
    } cell_op_t;

    // Command broadcast to every cell
    typedef struct packed {
        cell_op_t            op;
        logic [SLOT_W-1:0]   slot;
        logic [PRIO_W-1:0]   minp;
        logic [KEY_W-1:0]    key;
        logic [SIZE_W-1:0]   size;
        logic [PRIO_W-1:0]   prio;
    } cell_cmd_t;

    // Scan record handed from cell to cell
    typedef struct packed {
        logic [PRIO_W-1:0]   minp;
        logic [SLOT_W-1:0]   sel;
        logic [KEY_W-1:0]    sel_key;
        logic [SIZE_W-1:0]   sel_size;
        logic [PRIO_W-1:0]   maxp;
        logic                mfound;
        logic [SLOT_W-1:0]   mslot;
        logic [SIZE_W-1:0]   msize;
        logic [KEY_W-1:0]    lkey;
        logic [SIZE_W-1:0]   lsize;
        logic [PRIO_W-1:0]   lprio;
    } scan_t;

endpackage

@@ rtl/priority_cache_eviction.sv @@
// Top level: LFU cache policy with entry limit and byte budget over a row of slot cells.
// Each request runs a scan record through the row of ENTRIES slot cells, one cell a
// cycle. A hit or an insert without eviction costs one scan; every eviction (limit
// reached, byte budget reached, or flush) costs one more scan.
// One item is handled at a time; results come out in order, the final one with tlast.
module priority_cache_eviction
    import pce_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // res_key[31:0], res_bytes[55:32], boost[56], zero
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // slot[5:0], moved_from[11:6], entry_key[43:12],
                                   // entry_bytes[67:44], zero
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      cnt_reg;
    logic [31:0]        budget_reg;
    logic [SLOT_W-1:0]  limit_reg;
    logic [SLOT_W-1:0]  count_reg;
    logic [31:0]        used_reg;
    logic [PRIO_W-1:0]  max_reg;
    logic               mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  bytes_reg;
    logic               boost_reg;

    logic               m_valid_reg;
    logic [2:0]         m_kind_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic [SLOT_W-1:0]  m_moved_reg;
    logic [KEY_W-1:0]   m_key_reg;
    logic [SIZE_W-1:0]  m_bytes_reg;
    logic               m_last_reg;

    scan_t              wave [ENTRIES+1];
    cell_cmd_t          cmd;
    scan_t              w;
    logic               go;
    logic               can_emit;
    logic [SLOT_W-1:0]  limit_eff;
    logic               full;
    logic               short;
    logic [PRIO_W-1:0]  boost_prio;

    assign wave[0] = '{minp: PRIO_MAX, default: '0};

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        pce_cell #(.IDX(i)) u_cell (
            .clk      (clk),
            .wave_in  (wave[i]),
            .wave_out (wave[i+1]),
            .req_key  (key_reg),
            .count    (count_reg),
            .cmd      (cmd)
        );
    end

    assign w        = wave[ENTRIES];
    assign can_emit = !m_valid_reg || m_tready;
    assign go       = (state_reg == ST_SCAN) && (cnt_reg == CW'(ENTRIES)) && can_emit;

    always_comb
    begin
        if (limit_reg == '0)
            limit_eff = SLOT_W'(1);
        else if (limit_reg > SLOT_W'(ENTRIES))
            limit_eff = SLOT_W'(ENTRIES);
        else
            limit_eff = limit_reg;
    end

    assign full  = count_reg >= limit_eff;
    assign short = ({1'b0, used_reg} + 33'(bytes_reg)) >= {1'b0, budget_reg};
    assign boost_prio = (max_reg == PRIO_MAX) ? PRIO_MAX : max_reg + PRIO_W'(1);

    always_comb
    begin
        cmd = '0;
        cmd.op = OP_NONE;
        if (go)
        begin
            if (count_reg != '0 && (mode_reg || (!w.mfound && (full || short))))
            begin
                cmd.op   = OP_EVICT;
                cmd.slot = w.sel;
                cmd.minp = w.minp;
                cmd.key  = w.lkey;
                cmd.size = w.lsize;
                cmd.prio = w.lprio;
            end
            else if (!mode_reg && w.mfound)
            begin
                cmd.op   = OP_HIT;
                cmd.slot = w.mslot;
            end
            else if (!mode_reg && !full && !short)
            begin
                cmd.op   = OP_INSERT;
                cmd.slot = count_reg;
                cmd.key  = key_reg;
                cmd.size = bytes_reg;
                cmd.prio = boost_reg ? boost_prio : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            budget_reg  <= '0;
            limit_reg   <= SLOT_W'(32);
            count_reg   <= '0;
            used_reg    <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BUDGET)
                    budget_reg <= cfg_data;
                else
                    limit_reg <= cfg_data[SLOT_W-1:0];
            end
            if (m_valid_reg && m_tready && !go)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (cnt_reg != CW'(ENTRIES))
                        cnt_reg <= cnt_reg + CW'(1);
                    else if (can_emit)
                    begin
                        m_valid_reg <= 1'b1;
                        m_moved_reg <= (cmd.op == OP_EVICT) ? count_reg - SLOT_W'(1) : '0;
                        m_last_reg  <= (cmd.op != OP_EVICT);
                        state_reg   <= (cmd.op == OP_EVICT) ? ST_SCAN : ST_IDLE;
                        unique case (cmd.op)
                            OP_EVICT:
                            begin
                                m_kind_reg  <= KIND_EVICT;
                                m_slot_reg  <= w.sel;
                                m_key_reg   <= w.sel_key;
                                m_bytes_reg <= w.sel_size;
                                used_reg    <= used_reg - 32'(w.sel_size);
                                count_reg   <= count_reg - SLOT_W'(1);
                                max_reg     <= w.maxp - w.minp;
                                cnt_reg     <= '0;
                            end
                            OP_HIT:
                            begin
                                m_kind_reg  <= KIND_HIT;
                                m_slot_reg  <= w.mslot;
                                m_key_reg   <= key_reg;
                                m_bytes_reg <= w.msize;
                            end
                            OP_INSERT:
                            begin
                                m_kind_reg  <= KIND_INS;
                                m_slot_reg  <= count_reg;
                                m_key_reg   <= key_reg;
                                m_bytes_reg <= bytes_reg;
                                count_reg   <= count_reg + SLOT_W'(1);
                                used_reg    <= used_reg + 32'(bytes_reg);
                                if (boost_reg)
                                    max_reg <= boost_prio;
                            end
                            default:
                            begin
                                m_slot_reg <= '0;
                                if (mode_reg)
                                begin
                                    m_kind_reg  <= KIND_FLUSH;
                                    m_key_reg   <= '0;
                                    m_bytes_reg <= '0;
                                end
                                else
                                begin
                                    m_kind_reg  <= KIND_NOROOM;
                                    m_key_reg   <= key_reg;
                                    m_bytes_reg <= bytes_reg;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Request payload, captured on the accepted beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg  <= s_tuser;
            key_reg   <= s_tdata[31:0];
            bytes_reg <= s_tdata[55:32];
            boost_reg <= s_tdata[56];
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0, m_bytes_reg, m_key_reg, m_moved_reg, m_slot_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOT_W'(ENTRIES))
        else $error("entry count beyond capacity");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("scan counter overran");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while busy");

    a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_kind_reg == KIND_EVICT) |-> !m_last_reg)
        else $error("eviction flagged as final result");

endmodule

@@ rtl/pce_cell.sv @@
// One cache slot: holds key, size and priority and forwards the scan record.
module pce_cell
    import pce_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  logic              clk,
    input  scan_t             wave_in,
    output scan_t             wave_out,
    input  logic [KEY_W-1:0]  req_key,
    input  logic [SLOT_W-1:0] count,
    input  cell_cmd_t         cmd
);

    localparam logic [SLOT_W-1:0] MY = SLOT_W'(IDX);

    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [PRIO_W-1:0] prio_reg;
    scan_t             wave_reg;
    scan_t             wave_next;
    logic              live;

    assign live = MY < count;

    always_comb
    begin
        wave_next = wave_in;
        if (live)
        begin
            // <= keeps the last slot holding the minimum
            if (prio_reg <= wave_in.minp)
            begin
                wave_next.minp     = prio_reg;
                wave_next.sel      = MY;
                wave_next.sel_key  = key_reg;
                wave_next.sel_size = size_reg;
            end
            if (prio_reg > wave_in.maxp)
                wave_next.maxp = prio_reg;
            if (!wave_in.mfound && key_reg == req_key)
            begin
                wave_next.mfound = 1'b1;
                wave_next.mslot  = MY;
                wave_next.msize  = size_reg;
            end
            if (MY == count - SLOT_W'(1))
            begin
                wave_next.lkey  = key_reg;
                wave_next.lsize = size_reg;
                wave_next.lprio = prio_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg <= wave_next;
        case (cmd.op)
            OP_EVICT:
            begin
                if (live)
                begin
                    if (MY == cmd.slot)
                    begin
                        key_reg  <= cmd.key;
                        size_reg <= cmd.size;
                        prio_reg <= cmd.prio - cmd.minp;
                    end
                    else
                    begin
                        prio_reg <= prio_reg - cmd.minp;
                    end
                end
            end
            OP_HIT:
            begin
                if (MY == cmd.slot && prio_reg != PRIO_MAX)
                    prio_reg <= prio_reg + PRIO_W'(1);
            end
            OP_INSERT:
            begin
                if (MY == cmd.slot)
                begin
                    key_reg  <= cmd.key;
                    size_reg <= cmd.size;
                    prio_reg <= cmd.prio;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign wave_out = wave_reg;

endmodule

@@ test/priority_cache_eviction_test.sv @@
// Self-checking testbench for the LFU cache eviction block with entry and byte limits.
module priority_cache_eviction_test
    import pce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NSLOT = ENTRIES_DEF;
    localparam int unsigned WATCHDOG = 20000;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] moved;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] bytes;
        logic              last;
    } cache_result_t;

    class cache_scoreboard;
        logic [KEY_W-1:0]  keys [NSLOT];
        logic [SIZE_W-1:0] sizes [NSLOT];
        logic [PRIO_W-1:0] prios [NSLOT];
        int unsigned       count;
        logic [31:0]       used;
        logic [PRIO_W-1:0] maxp;
        logic [31:0]       budget;
        logic [5:0]        limit;
        cache_result_t     pending[$];
        int                mismatches;

        function new();
            count = 0;
            used = 0;
            maxp = 0;
            budget = 0;
            limit = 6'd32;
            mismatches = 0;
        endfunction

        function void evict_lowest();
            int unsigned sel;
            int unsigned lastidx;
            logic [PRIO_W-1:0] minp;
            cache_result_t r;
            sel = 0;
            minp = PRIO_MAX;
            for (int unsigned n = 0; n < count; n++)
                if (prios[n] <= minp)
                begin
                    minp = prios[n];
                    sel = n;
                end
            maxp = 0;
            for (int unsigned n = 0; n < count; n++)
            begin
                prios[n] = prios[n] - minp;
                if (prios[n] > maxp)
                    maxp = prios[n];
            end
            lastidx = count - 1;
            r = '{KIND_EVICT, sel[5:0], lastidx[5:0], keys[sel], sizes[sel], 1'b0};
            pending.push_back(r);
            used = used - 32'(sizes[sel]);
            keys[sel] = keys[lastidx];
            sizes[sel] = sizes[lastidx];
            prios[sel] = prios[lastidx];
            count = lastidx;
        endfunction

        function void note_config(logic idx, logic [31:0] data);
            if (idx == REG_BUDGET)
                budget = data;
            else
                limit = data[5:0];
        endfunction

        function void note_request(logic mode, logic [KEY_W-1:0] key,
                                   logic [SIZE_W-1:0] bytes, logic boost);
            int unsigned lim;
            cache_result_t r;
            if (mode)
            begin
                while (count > 0)
                    evict_lowest();
                pending.push_back('{KIND_FLUSH, 6'd0, 6'd0, 32'd0, 24'd0, 1'b1});
                return;
            end
            for (int unsigned n = 0; n < count; n++)
                if (keys[n] == key)
                begin
                    if (prios[n] != PRIO_MAX)
                        prios[n]++;
                    pending.push_back('{KIND_HIT, n[5:0], 6'd0, keys[n], sizes[n], 1'b1});
                    return;
                end
            lim = (limit == 0) ? 1 : limit;
            if (lim > NSLOT)
                lim = NSLOT;
            while (count > 0 && count >= lim)
                evict_lowest();
            while (count > 0 && 33'(used) + 33'(bytes) >= 33'(budget))
                evict_lowest();
            if (count >= lim || 33'(used) + 33'(bytes) >= 33'(budget))
                r = '{KIND_NOROOM, 6'd0, 6'd0, key, bytes, 1'b1};
            else
            begin
                if (boost && maxp != PRIO_MAX)
                    maxp++;
                keys[count] = key;
                sizes[count] = bytes;
                prios[count] = boost ? maxp : '0;
                r = '{KIND_INS, 6'(count), 6'd0, key, bytes, 1'b1};
                count++;
                used = used + 32'(bytes);
            end
            pending.push_back(r);
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    cache_scoreboard board;
    logic        hold_off;
    logic        sink_on;
    int unsigned quiet_cycles = 0;
    logic [KEY_W-1:0] key_pool [8];

    priority_cache_eviction DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_request(logic mode, logic [KEY_W-1:0] key,
                                logic [SIZE_W-1:0] bytes, logic boost, logic gaps);
        int unsigned gap;
        gap = gaps ? pick_gap() : 0;
        repeat (gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {7'd0, boost, bytes, key};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(mode, key, bytes, boost);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.note_config(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (2 * (NSLOT + 1) + 4) @(posedge clk);
    endtask

    task automatic random_request();
        logic [KEY_W-1:0] key;
        logic [SIZE_W-1:0] bytes;
        key = ($urandom_range(0, 2) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom();
        case ($urandom_range(0, 3))
            0: bytes = 24'($urandom());
            1: bytes = 24'hFFFFFF - 24'($urandom_range(0, 3));
            default: bytes = 24'($urandom_range(0, 4000));
        endcase
        send_request($urandom_range(0, 29) == 0, key, bytes, 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // sink: random stalls, plus one long hold-off requested by the stimulus
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else if (!sink_on)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result('{m_tuser, m_tdata[5:0], m_tdata[11:6], m_tdata[43:12],
                                 m_tdata[67:44], m_tlast});
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BUDGET;
        cfg_data = '0;
        hold_off = 1'b0;
        sink_on = 1'b0;
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero budget: every miss is a no room error
        send_request(1'b0, 32'h0, 24'h0, 1'b0, 1'b0);
        send_request(1'b1, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        drain();
        write_reg(REG_BUDGET, 32'hFFFFFFFF);
        write_reg(REG_LIMIT, 32'd3);
        send_request(1'b0, 32'h0, 24'h0, 1'b0, 1'b0);
        send_request(1'b0, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_request(1'b0, 32'h12345678, 24'h10, 1'b1, 1'b0);
        send_request(1'b0, 32'h0, 24'h5, 1'b0, 1'b0);
        // limit reached: evictions before insert, including the last slot
        send_request(1'b0, 32'hA5A5A5A5, 24'h1, 1'b0, 1'b0);
        send_request(1'b0, 32'h5A5A5A5A, 24'h1, 1'b1, 1'b0);
        send_request(1'b1, 32'h0, 24'h0, 1'b0, 1'b0);
        send_request(1'b1, 32'h0, 24'h0, 1'b0, 1'b0);
        drain();
        // entry limit of zero acts as one; above the table acts as the table size
        write_reg(REG_LIMIT, 32'd0);
        send_request(1'b0, 32'h1, 24'h1, 1'b0, 1'b0);
        send_request(1'b0, 32'h2, 24'h1, 1'b1, 1'b0);
        drain();
        write_reg(REG_LIMIT, 32'd63);
        write_reg(REG_BUDGET, 32'd100);
        send_request(1'b0, 32'h3, 24'd60, 1'b0, 1'b0);
        send_request(1'b0, 32'h4, 24'd39, 1'b0, 1'b0);
        send_request(1'b0, 32'h5, 24'd100, 1'b0, 1'b0);
        send_request(1'b0, 32'h6, 24'd99, 1'b1, 1'b0);
        // repeated hits on a boosted entry, then a flush
        for (int i = 0; i < 3; i++)
            send_request(1'b0, 32'h6, 24'd0, 1'b0, 1'b0);
        send_request(1'b1, 32'h0, 24'h0, 1'b0, 1'b0);
        drain();

        sink_on = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_BUDGET, 32'hFFFFFFFF); write_reg(REG_LIMIT, 32'd63); end
                1: begin write_reg(REG_BUDGET, 32'd12000); write_reg(REG_LIMIT, 32'd5); end
                2: begin write_reg(REG_BUDGET, $urandom()); write_reg(REG_LIMIT, 32'd1); end
                default: begin write_reg(REG_BUDGET, 32'd30000000); write_reg(REG_LIMIT, 32'd32); end
            endcase
            if (phase == 1)
            begin
                // long receiver stall while the sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    for (int i = 0; i < 10; i++)
                        random_request();
                join
            end
            for (int i = 0; i < 45; i++)
                random_request();
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
